### hw/rtl/lruosl_pkg.sv
// shared types, codes and defaults of the lru open-slot limiter
`default_nettype none

package lruosl_pkg;

    // default sizes of the slot table
    localparam int MAX_SLOTS_DEF  = 32;
    localparam int STAMP_BITS_DEF = 32;

    // open limit after reset
    localparam logic [7:0] OPEN_LIMIT_RST = 8'd20;

    // register index of the open limit (word address bit)
    localparam logic REG_OPEN_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        CMD_REGISTER   = 2'd0,
        CMD_UNREGISTER = 2'd1,
        CMD_TOUCH      = 2'd2,
        CMD_ENFORCE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_EVICT      = 2'd0,
        KIND_REGISTERED = 2'd1,
        KIND_DONE       = 2'd2,
        KIND_ERROR      = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD_INDEX  = 3'd1,
        ERR_NOT_OPEN   = 3'd2,
        ERR_NO_VICTIM  = 3'd3,
        ERR_TABLE_FULL = 3'd4
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_EVICT,
        ST_REGISTER
    } state_t;

    // one result beat handed from the controller to the output register
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  index;
        err_t        err;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/lruosl_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module lruosl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lruosl_cfg.sv
// apb register file holding the open limit
`default_nettype none

module lruosl_cfg
    import lruosl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [7:0]  open_limit
);

    logic [7:0] limit_reg;
    logic       wr_en;

    // write strobe in the access phase
    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_OPEN_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= OPEN_LIMIT_RST;
        end
        else if (wr_en)
        begin
            limit_reg <= pwdata[7:0];
        end
    end

    // read back
    assign prdata     = (paddr[2] == REG_OPEN_LIMIT) ? {24'd0, limit_reg} : 32'd0;
    assign pready     = 1'b1;
    assign open_limit = limit_reg;

endmodule

`default_nettype wire

### hw/rtl/lruosl_ctrl.sv
// command sequencer: slot bookkeeping, stamp scan over the ram, result beats
`default_nettype none

module lruosl_ctrl
    import lruosl_pkg::*;
#(
    parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] open_limit,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire cmd_t       in_cmd,
    input  wire logic [7:0] in_index,
    output logic            push_valid,
    input  wire logic       push_ready,
    output result_t         push_res
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg;
    logic [7:0]            idx_reg;
    logic [MAX_SLOTS-1:0]  open_reg;
    logic [CW-1:0]         alloc_reg;
    logic [CW-1:0]         cnt_reg;
    logic [STAMP_BITS-1:0] stamp_reg;
    logic [CW-1:0]         scan_reg;
    logic                  pend_reg;
    logic [IW-1:0]         pend_idx_reg;
    logic                  found_reg;
    logic [IW-1:0]         best_idx_reg;
    logic [STAMP_BITS-1:0] best_stamp_reg;

    logic [7:0]            lim;
    logic [8:0]            cnt_ext;
    logic [8:0]            lim_ext;
    logic                  need_evict;
    logic                  over_limit;
    logic                  idx_bad;
    logic                  table_full;
    logic [IW-1:0]         idx_sel;
    logic                  scan_done;
    logic                  fire;
    logic                  start_scan;
    logic                  act_close;
    logic                  act_reg;
    logic                  act_touch;
    logic [IW-1:0]         close_idx;
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic                  ram_re;
    logic [STAMP_BITS-1:0] ram_rdata;

    // limit of zero acts as one
    assign lim        = (open_limit == 8'd0) ? 8'd1 : open_limit;
    assign cnt_ext    = 9'(cnt_reg);
    assign lim_ext    = {1'b0, lim};
    assign need_evict = (cnt_ext + 9'd1) >= lim_ext;
    assign over_limit = cnt_ext >= lim_ext;
    assign idx_bad    = idx_reg >= 8'(alloc_reg);
    assign table_full = alloc_reg == CW'(MAX_SLOTS);
    assign idx_sel    = idx_reg[IW-1:0];
    assign scan_done  = (scan_reg == alloc_reg) && !pend_reg;
    assign fire       = push_valid && push_ready;
    assign in_ready   = (state_reg == ST_IDLE);

    // result beat and side effects of the current state
    always_comb
    begin
        push_valid = 1'b0;
        push_res   = '{kind: KIND_DONE, index: idx_reg, err: ERR_NONE, last: 1'b1};
        start_scan = 1'b0;
        act_close  = 1'b0;
        act_reg    = 1'b0;
        act_touch  = 1'b0;
        close_idx  = idx_sel;
        unique case (state_reg)
            ST_DISPATCH:
            begin
                unique case (cmd_reg)
                    CMD_REGISTER:
                    begin
                        if (table_full)
                        begin
                            push_valid = 1'b1;
                            push_res   = '{kind: KIND_ERROR, index: 8'd0,
                                           err: ERR_TABLE_FULL, last: 1'b1};
                        end
                        else if (need_evict)
                        begin
                            start_scan = 1'b1;
                        end
                        else
                        begin
                            push_valid = 1'b1;
                            act_reg    = 1'b1;
                            push_res   = '{kind: KIND_REGISTERED, index: 8'(alloc_reg),
                                           err: ERR_NONE, last: 1'b1};
                        end
                    end
                    CMD_UNREGISTER:
                    begin
                        push_valid = 1'b1;
                        if (idx_bad)
                        begin
                            push_res.kind = KIND_ERROR;
                            push_res.err  = ERR_BAD_INDEX;
                        end
                        else if (!open_reg[idx_sel])
                        begin
                            push_res.kind = KIND_ERROR;
                            push_res.err  = ERR_NOT_OPEN;
                        end
                        else
                        begin
                            act_close = 1'b1;
                        end
                    end
                    CMD_TOUCH:
                    begin
                        push_valid = 1'b1;
                        if (idx_bad)
                        begin
                            push_res.kind = KIND_ERROR;
                            push_res.err  = ERR_BAD_INDEX;
                        end
                        else
                        begin
                            act_touch = 1'b1;
                        end
                    end
                    CMD_ENFORCE:
                    begin
                        if (over_limit)
                        begin
                            start_scan = 1'b1;
                        end
                        else
                        begin
                            push_valid     = 1'b1;
                            push_res.index = 8'd0;
                        end
                    end
                endcase
            end
            ST_EVICT:
            begin
                push_valid = 1'b1;
                if (!found_reg)
                begin
                    push_res = '{kind: KIND_ERROR, index: 8'd0,
                                 err: ERR_NO_VICTIM, last: 1'b1};
                end
                else
                begin
                    act_close = 1'b1;
                    close_idx = best_idx_reg;
                    push_res  = '{kind: KIND_EVICT, index: 8'(best_idx_reg),
                                  err: ERR_NONE, last: 1'b0};
                end
            end
            ST_REGISTER:
            begin
                push_valid = 1'b1;
                act_reg    = 1'b1;
                push_res   = '{kind: KIND_REGISTERED, index: 8'(alloc_reg),
                               err: ERR_NONE, last: 1'b1};
            end
            default:
            begin
                push_valid = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (start_scan)
                begin
                    state_next = ST_SCAN;
                end
                else if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                if (fire)
                begin
                    if (!found_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (cmd_reg == CMD_REGISTER)
                    begin
                        state_next = ST_REGISTER;
                    end
                    else
                    begin
                        state_next = ST_DISPATCH;
                    end
                end
            end
            ST_REGISTER:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // stamp ram: writes only outside the scan, so read and write never overlap
    assign ram_we    = fire && (act_reg || act_touch);
    assign ram_waddr = act_reg ? alloc_reg[IW-1:0] : idx_sel;
    assign ram_re    = (state_reg == ST_SCAN) && (scan_reg != alloc_reg);

    lruosl_ram #(
        .WIDTH (STAMP_BITS),
        .DEPTH (MAX_SLOTS)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (stamp_reg),
        .re    (ram_re),
        .raddr (scan_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    // state register and command capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= in_cmd;
            idx_reg <= in_index;
        end
    end

    // slot bookkeeping and stamp counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= '0;
            alloc_reg <= '0;
            cnt_reg   <= '0;
            stamp_reg <= STAMP_BITS'(1);
        end
        else if (fire)
        begin
            if (act_close)
            begin
                open_reg[close_idx] <= 1'b0;
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
            if (act_reg)
            begin
                open_reg[alloc_reg[IW-1:0]] <= 1'b1;
                alloc_reg                   <= alloc_reg + CW'(1);
                cnt_reg                     <= cnt_reg + CW'(1);
            end
            if ((act_reg || act_touch) && (stamp_reg != STAMP_MAX))
            begin
                stamp_reg <= stamp_reg + STAMP_BITS'(1);
            end
        end
    end

    // oldest-stamp scan, one ram read a cycle, compare in the cycle after the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (start_scan)
        begin
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (state_reg == ST_SCAN)
        begin
            pend_reg <= ram_re;
            if (ram_re)
            begin
                scan_reg <= scan_reg + CW'(1);
            end
            if (pend_reg && open_reg[pend_idx_reg]
                && (!found_reg || (ram_rdata < best_stamp_reg)))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN)
        begin
            pend_idx_reg <= scan_reg[IW-1:0];
            if (pend_reg && open_reg[pend_idx_reg]
                && (!found_reg || (ram_rdata < best_stamp_reg)))
            begin
                best_idx_reg   <= pend_idx_reg;
                best_stamp_reg <= ram_rdata;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lru_open_slot_limiter.sv
// top level of the lru open-slot limiter
// Commands arrive on the s_ stream: s_tuser carries the command (register,
// unregister, touch, enforce limit), s_tdata the slot index. Results leave on
// the m_ stream: m_tuser is the result kind, m_tdata the slot index and error
// code, m_tlast marks the final beat of a command. Register 0 on the apb port
// holds the open limit (reset value 20, zero acts as one).
// One command is worked on at a time. Every eviction is a scan of the stamp
// ram over the allocated slots, one slot per cycle, before the victim is
// closed: register scans when the new slot would reach the limit, enforce
// scans and evicts again for as long as the open count is at the limit or over.
// The stamp ram read port paces the scan; the open marks live in flip-flops.
// Reset closes every slot, clears the allocation and open counts and sets the
// stamp counter to one; the stamp ram itself is not cleared since a stamp is
// only read for allocated slots.
// A result register sits on the output: a new command is accepted while a
// result waits, and a stalled receiver just holds the sequencer at its next
// result beat with no loss.
`default_nettype none

module lru_open_slot_limiter
    import lruosl_pkg::*;
#(
    parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] slot_index
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [7:0] result_index, [10:8] error_code, zero fill
    output logic      [1:0]  m_tuser,   // [1:0] kind
    output logic             m_tlast,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [7:0] open_limit;
    logic       push_valid;
    logic       push_ready;
    result_t    push_res;
    logic       out_valid_reg;
    result_t    out_data_reg;

    lruosl_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .open_limit (open_limit)
    );

    lruosl_ctrl #(
        .MAX_SLOTS  (MAX_SLOTS),
        .STAMP_BITS (STAMP_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .open_limit (open_limit),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (cmd_t'(s_tuser)),
        .in_index   (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_res   (push_res)
    );

    // output register
    assign push_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push_ready)
        begin
            out_valid_reg <= push_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            out_data_reg <= push_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_data_reg.err, out_data_reg.index};
    assign m_tuser  = out_data_reg.kind;
    assign m_tlast  = out_data_reg.last;

    // checks

    // the sequencer never offers a result while it waits for a command
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && push_valid))
        else $error("result offered while idle");

    // an eviction beat is never the final beat of a command
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.kind == KIND_EVICT)) |-> !out_data_reg.last)
        else $error("eviction marked last");

    // error code is set on error beats and only there
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((out_data_reg.kind == KIND_ERROR) == (out_data_reg.err != ERR_NONE)))
        else $error("error code does not match kind");

    // a registered index always ends the command
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.kind == KIND_REGISTERED)) |-> out_data_reg.last)
        else $error("registered index not last");

endmodule

`default_nettype wire
